// ----- hdl/dap_pkg.sv -----
// ============================================================================
// dap_pkg: shared types and constants of the decimal amount parser
// Character codes, parse phases, result status codes and the powers of ten
// used to weight whole and fraction digits.
// ============================================================================
package dap_pkg;

	localparam int FRACTION_DIGITS = 6;

	localparam int AmountW = 64;
	localparam int CharW   = 8;
	localparam int DigitW  = 4;
	// fraction digit count, wide enough to hold FRACTION_DIGITS itself
	localparam int CountW  = $clog2(FRACTION_DIGITS + 2);
	localparam int PowIdxW = 5;
	// accumulator times ten plus a weighted digit fits this width
	localparam int SumW    = AmountW + 5;
	localparam int ProdW   = AmountW + DigitW;

	localparam logic [CharW-1:0] CH_PLUS  = 8'h2B;
	localparam logic [CharW-1:0] CH_MINUS = 8'h2D;
	localparam logic [CharW-1:0] CH_POINT = 8'h2E;
	localparam logic [CharW-1:0] CH_ZERO  = 8'h30;
	localparam logic [CharW-1:0] CH_NINE  = 8'h39;

	localparam logic [AmountW-1:0] POW10 [20] = '{
		64'd1,
		64'd10,
		64'd100,
		64'd1000,
		64'd10000,
		64'd100000,
		64'd1000000,
		64'd10000000,
		64'd100000000,
		64'd1000000000,
		64'd10000000000,
		64'd100000000000,
		64'd1000000000000,
		64'd10000000000000,
		64'd100000000000000,
		64'd1000000000000000,
		64'd10000000000000000,
		64'd100000000000000000,
		64'd1000000000000000000,
		64'd10000000000000000000
	};

	// atoms per whole unit
	localparam logic [AmountW-1:0] COIN = POW10[FRACTION_DIGITS];

	typedef enum logic [1:0] {
		PH_START,
		PH_WHOLE,
		PH_FRAC,
		PH_DONE
	} phase_t;

	typedef enum logic [1:0] {
		ST_OK,
		ST_EMPTY,
		ST_FRAC,
		ST_OVER
	} status_t;

	typedef struct packed {
		logic [AmountW-1:0] amount;
		status_t            status;
	} fin_t;

endpackage

// ----- hdl/dap_text_if.sv -----
// ============================================================================
// dap_text_if: character channel
// One character byte per transfer, with a terminator flag that ends the string.
// ============================================================================
interface dap_text_if;
	logic       valid;
	logic       ready;
	logic [7:0] ch;
	logic       terminator;

	modport source (output valid, output ch, output terminator, input ready);
	modport sink (input valid, input ch, input terminator, output ready);
endinterface

// ----- hdl/dap_result_if.sv -----
// ============================================================================
// dap_result_if: result channel
// One parsed amount in atoms and its status code per transfer.
// ============================================================================
interface dap_result_if;
	logic        valid;
	logic        ready;
	logic [63:0] amount;
	logic [1:0]  status;

	modport source (output valid, output amount, output status, input ready);
	modport sink (input valid, input amount, input status, output ready);
endinterface

// ----- hdl/dap_scan.sv -----
// ============================================================================
// dap_scan: character scanner and atom accumulator
// Tracks the parse phase and keeps the running amount in atoms, with sticky
// overflow and fraction error flags; presents the finished result for the
// string seen so far.
// ============================================================================
module dap_scan (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                adv,
	input  logic [7:0]          ch,
	input  logic                terminator,
	output dap_pkg::fin_t       fin,
	output logic                fresh
);
	import dap_pkg::*;

	phase_t               phase_q, phase_d;
	logic [AmountW-1:0]   acc_q, acc_d;
	logic                 ovf_q, ovf_d;
	logic [CountW-1:0]    cnt_q, cnt_d;
	logic                 neg_q, neg_d;
	logic                 ferr_q, ferr_d;

	logic                 is_digit, is_sign, is_point, room, in_frac;
	logic                 take_whole, take_frac, frac_over;
	logic [DigitW-1:0]    digit;
	logic [PowIdxW-1:0]   pow_idx;
	logic [AmountW-1:0]   weight;
	logic [ProdW-1:0]     prod;
	logic [SumW-1:0]      base, sum;
	logic                 sum_ovf;

	assign is_digit = ch inside {[CH_ZERO:CH_NINE]};
	assign is_sign  = (ch == CH_PLUS) || (ch == CH_MINUS);
	assign is_point = ch == CH_POINT;
	assign digit    = DigitW'(ch - CH_ZERO);
	assign room     = cnt_q < CountW'(FRACTION_DIGITS);
	assign in_frac  = phase_q == PH_FRAC;

	assign take_whole = (phase_q == PH_START || phase_q == PH_WHOLE) && is_digit;
	assign take_frac  = in_frac && is_digit && room;
	assign frac_over  = in_frac && is_digit && !room;

	// place weight of a fraction digit: 10^(FRACTION_DIGITS-1-count)
	assign pow_idx = room ? PowIdxW'(FRACTION_DIGITS - 1) - PowIdxW'(cnt_q) : '0;
	assign weight  = in_frac ? POW10[pow_idx] : COIN;
	assign prod    = ProdW'(digit) * ProdW'(weight);
	assign base    = in_frac ? SumW'(acc_q)
	                         : ({2'b00, acc_q, 3'b000} + {4'b0000, acc_q, 1'b0});
	assign sum     = base + SumW'(prod);
	assign sum_ovf = |sum[SumW-1:AmountW];

	// next phase
	always_comb begin
		phase_d = phase_q;
		if (terminator) begin
			phase_d = PH_START;
		end else begin
			case (phase_q)
				PH_START, PH_WHOLE: begin
					if (phase_q == PH_START && is_sign) begin
						phase_d = PH_WHOLE;
					end else if (is_digit) begin
						phase_d = PH_WHOLE;
					end else if (is_point) begin
						phase_d = PH_FRAC;
					end else begin
						phase_d = PH_DONE;
					end
				end
				PH_FRAC: begin
					if (!is_digit || !room) begin
						phase_d = PH_DONE;
					end
				end
				default: phase_d = phase_q;
			endcase
		end
	end

	// accumulator and flags
	always_comb begin
		acc_d  = acc_q;
		ovf_d  = ovf_q;
		cnt_d  = cnt_q;
		neg_d  = neg_q;
		ferr_d = ferr_q;
		if (terminator) begin
			acc_d  = '0;
			ovf_d  = 1'b0;
			cnt_d  = '0;
			neg_d  = 1'b0;
			ferr_d = 1'b0;
		end else begin
			if (phase_q == PH_START && is_sign) begin
				neg_d = ch == CH_MINUS;
			end
			if ((take_whole || take_frac) && !ovf_q) begin
				if (sum_ovf) begin
					ovf_d = 1'b1;
				end else begin
					acc_d = sum[AmountW-1:0];
				end
			end
			if (take_frac) begin
				cnt_d = cnt_q + CountW'(1);
			end
			if (frac_over) begin
				ferr_d = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START;
			acc_q   <= '0;
			ovf_q   <= 1'b0;
			cnt_q   <= '0;
			neg_q   <= 1'b0;
			ferr_q  <= 1'b0;
		end else if (adv) begin
			phase_q <= phase_d;
			acc_q   <= acc_d;
			ovf_q   <= ovf_d;
			cnt_q   <= cnt_d;
			neg_q   <= neg_d;
			ferr_q  <= ferr_d;
		end
	end

	// result for the string seen so far; fraction error wins over overflow
	always_comb begin
		fin.amount = '0;
		if (phase_q == PH_START) begin
			fin.status = ST_EMPTY;
		end else if (ferr_q) begin
			fin.status = ST_FRAC;
		end else if (ovf_q || (neg_q && acc_q != '0)) begin
			fin.status = ST_OVER;
		end else begin
			fin.status = ST_OK;
			fin.amount = acc_q;
		end
	end

	assign fresh = phase_q == PH_START;

endmodule

// ----- hdl/dap_outreg.sv -----
// ============================================================================
// dap_outreg: result register
// Holds one finished result until the result channel takes it.
// ============================================================================
module dap_outreg (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  dap_pkg::fin_t       fin,
	output logic                hold,
	dap_result_if.source        result
);
	import dap_pkg::*;

	logic               valid_q;
	logic [AmountW-1:0] amount_q;
	status_t            status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (result.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			amount_q <= fin.amount;
			status_q <= fin.status;
		end
	end

	assign hold          = valid_q && !result.ready;
	assign result.valid  = valid_q;
	assign result.amount = amount_q;
	assign result.status = status_q;

endmodule

// ----- hdl/decimal_amount_parser.sv -----
// ============================================================================
// decimal_amount_parser: decimal amount string to fixed-point atoms
// Character-serial parser with an input register, a scanner and a result
// register.
// ============================================================================
// The block takes one character per transfer on text and one transfer per
// cycle while text is not stalled. A string is an optional '+' or '-', whole
// digits, and an optional '.' with up to FRACTION_DIGITS fraction digits;
// the first character outside that form ends the parse and the rest is
// ignored up to the terminator. A transfer with terminator set gives one
// result: amount in atoms (whole * 10^FRACTION_DIGITS + scaled fraction) and
// a status of ok, empty, too many fraction digits or overflow; amount is zero
// for any status other than ok, and a nonzero negative amount reports overflow.
// The result appears on result after passing the input register and then the
// result register. The atom accumulator in the scanner takes each digit with a
// single multiply-by-ten and add, the multiply for whole digits only. The text
// channel stalls only while a terminator waits in the input register and the
// previous result is still held by the result channel.
module decimal_amount_parser (
	input  logic          clk,
	input  logic          arst_n,
	dap_text_if.sink      text,
	dap_result_if.source  result
);
	import dap_pkg::*;

	// input register
	logic             valid_s1;
	logic [CharW-1:0] ch_s1;
	logic             term_s1;

	logic             adv_s1;
	logic             hold;
	logic             fresh;
	fin_t             fin;

	// advance the input register unless a terminator must wait for the
	// result register to drain
	assign adv_s1     = valid_s1 && !(term_s1 && hold);
	assign text.ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text.ready) begin
			valid_s1 <= text.valid;
		end
	end

	// capture the payload on each transfer
	always_ff @(posedge clk) begin
		if (text.valid && text.ready) begin
			ch_s1   <= text.ch;
			term_s1 <= text.terminator;
		end
	end

	// scanner: update phase and accumulator, present the finished result
	dap_scan u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (adv_s1),
		.ch         (ch_s1),
		.terminator (term_s1),
		.fin        (fin),
		.fresh      (fresh)
	);

	// result register: load on each terminator that advances
	dap_outreg u_outreg (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (adv_s1 && term_s1),
		.fin    (fin),
		.hold   (hold),
		.result (result)
	);

	// any status other than ok carries a zero amount
	assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.status != ST_OK |-> result.amount == '0)
		else $error("nonzero amount with error status");

	// a terminator returns the scanner to its start phase
	assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && term_s1 |=> fresh)
		else $error("scanner not cleared after terminator");

	// a terminator that advances always leaves a result to transfer
	assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && term_s1 |=> result.valid)
		else $error("result lost after terminator");

endmodule
